// ----- hw/rtl/sot_pkg.sv -----
// shared types and constants for the sorted uid object table
`default_nettype none
package sot_pkg;

  localparam logic [2:0] MODE_LOOKUP     = 3'd0;
  localparam logic [2:0] MODE_INSERT     = 3'd1;
  localparam logic [2:0] MODE_REMOVE     = 3'd2;
  localparam logic [2:0] MODE_WALK_FIRST = 3'd3;
  localparam logic [2:0] MODE_WALK_NEXT  = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_DUP       = 3'd3;
  localparam logic [2:0] ST_WALK_END  = 3'd4;

  // object types whose allocated keys take the default owner
  localparam logic [7:0] TYPE_DFLT_A = 8'd0;
  localparam logic [7:0] TYPE_DFLT_B = 8'd5;
  localparam logic [7:0] TYPE_DFLT_C = 8'd6;
  localparam logic [7:0] TYPE_DFLT_D = 8'd7;

  localparam int unsigned CNT_MIN = 1000;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] key;
    logic [31:0] obj_handle;
    logic [7:0]  obj_type;
    logic [2:0]  obj_owner;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_handle;
    logic [31:0] out_key;
    logic [10:0] slot_index;
  } out_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] handle;
  } entry_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] handle;
    logic [31:0] stamp;
  } cell_ent_t;

  typedef enum logic [1:0] {CELL_HOLD, CELL_INS, CELL_DEL, CELL_STAMP} cell_op_e;
  typedef enum logic {QRY_LB, QRY_WALK} qry_e;

  typedef struct packed {
    cell_op_e    op;
    qry_e        qry;
    logic [31:0] q_key;
    entry_t      new_ent;
    logic [31:0] pass;
  } ctrl_t;

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_SRCH, S_EXEC, S_DONE} state_e;

endpackage
`default_nettype wire

// ----- hw/rtl/sot_cell.sv -----
// one table entry cell: holds key, handle and stamp, shifts with its neighbors
`default_nettype none
module sot_cell #(
  parameter int unsigned IW = 11
) (
  input  wire                      clk_i,
  input  wire sot_pkg::ctrl_t      ctrl_i,
  input  wire  [IW-1:0]            idx_i,
  input  wire  [IW-1:0]            pos_i,
  input  wire  [IW-1:0]            count_i,
  input  wire  [IW-1:0]            cursor_i,
  input  wire sot_pkg::cell_ent_t  left_i,
  input  wire sot_pkg::cell_ent_t  right_i,
  output sot_pkg::cell_ent_t       ent_o,
  output logic                     hit_o
);
  sot_pkg::cell_ent_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    case (ctrl_i.op)
      sot_pkg::CELL_INS: begin
        if (idx_i > pos_i) begin
          ent_d = left_i;
        end else if (idx_i == pos_i) begin
          ent_d = {ctrl_i.new_ent.key, ctrl_i.new_ent.handle, 32'd0};
        end
      end
      sot_pkg::CELL_DEL: begin
        if (idx_i >= pos_i) begin
          ent_d = right_i;
        end
      end
      sot_pkg::CELL_STAMP: begin
        if (idx_i == pos_i) begin
          ent_d.stamp = ctrl_i.pass;
        end
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  // LB: at/past count or key not below; walk: unstamped, cursor<idx<count
  always_comb begin
    case (ctrl_i.qry)
      sot_pkg::QRY_LB:   hit_o = (idx_i >= count_i) || (ent_q.key >= ctrl_i.q_key);
      sot_pkg::QRY_WALK: hit_o = (idx_i > cursor_i) && (idx_i < count_i) &&
                                 (ent_q.stamp != ctrl_i.pass);
      default:           hit_o = 1'b0;
    endcase
  end

  assign ent_o = ent_q;
endmodule
`default_nettype wire

// ----- hw/rtl/sot_tree.sv -----
// registered find-first tree over the cell hit flags
`default_nettype none
module sot_tree #(
  parameter int unsigned NL = 10,
  parameter int unsigned IW = 11
) (
  input  wire                      clk_i,
  input  wire                      hit_i [1<<NL],
  input  wire  [IW-1:0]            idx_i [1<<NL],
  input  wire sot_pkg::entry_t     ent_i [1<<NL],
  output logic                     hit_o,
  output logic [IW-1:0]            idx_o,
  output sot_pkg::entry_t          ent_o
);
  localparam int unsigned NP = 1 << NL;

  logic            hit_q [NL+1][NP];
  logic [IW-1:0]   idx_q [NL+1][NP];
  sot_pkg::entry_t ent_q [NL+1][NP];

  for (genvar n = 0; n < NP; n++) begin : g_leaf
    always_ff @(posedge clk_i) begin
      hit_q[0][n] <= hit_i[n];
      idx_q[0][n] <= idx_i[n];
      ent_q[0][n] <= ent_i[n];
    end
  end

  for (genvar k = 1; k <= NL; k++) begin : g_lvl
    for (genvar n = 0; n < (NP >> k); n++) begin : g_node
      always_ff @(posedge clk_i) begin
        hit_q[k][n] <= hit_q[k-1][2*n] | hit_q[k-1][2*n+1];
        idx_q[k][n] <= hit_q[k-1][2*n] ? idx_q[k-1][2*n] : idx_q[k-1][2*n+1];
        ent_q[k][n] <= hit_q[k-1][2*n] ? ent_q[k-1][2*n] : ent_q[k-1][2*n+1];
      end
    end
  end

  assign hit_o = hit_q[NL][0];
  assign idx_o = idx_q[NL][0];
  assign ent_o = ent_q[NL][0];
endmodule
`default_nettype wire

// ----- hw/rtl/sorted_uid_object_table.sv -----
// top level of the sorted uid object table
`default_nettype none
// Sorted key/handle table held in a row of CAPACITY cells, one entry per cell,
// kept in ascending unsigned key order. Every cell compares its own key with
// the broadcast search key; a registered find-first tree of log2(CAPACITY)+1
// stages turns those flags into the lower-bound slot; lookup, insert, remove
// and walk-next wait in a search state for that tree to settle. Walk-first,
// unused modes and walk-next at the table end skip the search. Insert and remove
// shift the whole tail at once, each cell taking its left or right neighbor. One
// item is in flight at a time; a finished item waits in the output register while
// the next one is taken. Allocated keys are owner<<COUNTER_BITS | counter, counters
// start at 1000 and fold back to 1000 past their top value. No clearing pass is needed.
module sorted_uid_object_table #(
  parameter int unsigned CAPACITY     = 1024,
  parameter int unsigned COUNTER_BITS = 29
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire sot_pkg::in_t in_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output sot_pkg::out_t     out_o,
  input  wire               cfg_we_i,
  input  wire  [2:0]        cfg_wdata_i
);
  localparam int unsigned NL = $clog2(CAPACITY);
  localparam int unsigned NP = 1 << NL;
  localparam int unsigned IW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = $clog2(NL + 2);
  localparam int unsigned CB = COUNTER_BITS;

  // control state
  sot_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [IW-1:0]   count_q, count_d;
  logic [IW-1:0]   cursor_q, cursor_d;
  logic [31:0]     pass_q, pass_d;
  logic [2:0]      dflt_owner_q;
  logic [CB-1:0]   ctr_q [8];
  logic [CB-1:0]   ctr_d;
  logic [2:0]      ctr_sel;
  logic            ctr_we;
  logic            out_valid_q, out_valid_d;
  sot_pkg::out_t   out_q, out_d;

  // item registers
  sot_pkg::in_t    it_q, it_d;
  sot_pkg::qry_e   qry_q, qry_d;
  logic [31:0]     qkey_q, qkey_d;
  sot_pkg::out_t   res_q, res_d;

  // cell row and tree
  sot_pkg::ctrl_t     ctrl;
  sot_pkg::cell_ent_t ent [CAPACITY];
  logic               leaf_hit [NP];
  logic [IW-1:0]      leaf_idx [NP];
  sot_pkg::entry_t    leaf_ent [NP];
  logic               t_hit;
  logic [IW-1:0]      t_idx;
  sot_pkg::entry_t    t_ent;
  logic [IW-1:0]      pos;

  // allocation datapath
  logic            dflt_type;
  logic [2:0]      own;
  logic [CB-1:0]   ctr_cur;
  logic [CB:0]     ctr_nxt, ctr_need, ctr_upd;
  logic [31:0]     uid;
  logic            found;
  logic [IW-1:0]   cur_inc;

  for (genvar n = 0; n < CAPACITY; n++) begin : g_cell
    sot_pkg::cell_ent_t lft, rgt;
    if (n == 0) begin : g_first
      assign lft = '0;
    end else begin : g_mid_l
      assign lft = ent[n-1];
    end
    if (n == CAPACITY - 1) begin : g_last
      assign rgt = '0;
    end else begin : g_mid_r
      assign rgt = ent[n+1];
    end
    sot_cell #(.IW(IW)) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .idx_i    (IW'(n)),
      .pos_i    (pos),
      .count_i  (count_q),
      .cursor_i (cursor_q),
      .left_i   (lft),
      .right_i  (rgt),
      .ent_o    (ent[n]),
      .hit_o    (leaf_hit[n])
    );
    assign leaf_idx[n] = IW'(n);
    assign leaf_ent[n] = {ent[n].key, ent[n].handle};
  end

  // padding leaves sit past the table end, so they only matter for lower bound
  for (genvar n = CAPACITY; n < NP; n++) begin : g_pad
    assign leaf_hit[n] = (qry_q == sot_pkg::QRY_LB);
    assign leaf_idx[n] = IW'(CAPACITY);
    assign leaf_ent[n] = '0;
  end

  sot_tree #(.NL(NL), .IW(IW)) u_tree (
    .clk_i (clk_i),
    .hit_i (leaf_hit),
    .idx_i (leaf_idx),
    .ent_i (leaf_ent),
    .hit_o (t_hit),
    .idx_o (t_idx),
    .ent_o (t_ent)
  );

  assign pos   = t_hit ? t_idx : count_q;
  assign found = t_hit && (t_idx < count_q) && (t_ent.key == qkey_q);
  assign cur_inc = cursor_q + IW'(1);

  // owner and key for insert
  always_comb begin
    dflt_type = (it_q.obj_type == sot_pkg::TYPE_DFLT_A) ||
                (it_q.obj_type == sot_pkg::TYPE_DFLT_B) ||
                (it_q.obj_type == sot_pkg::TYPE_DFLT_C) ||
                (it_q.obj_type == sot_pkg::TYPE_DFLT_D);
    own      = ((it_q.key == 32'd0) && dflt_type) ? dflt_owner_q : it_q.obj_owner;
    ctr_cur  = ctr_q[own];
    ctr_nxt  = {1'b0, ctr_cur} + (CB+1)'(1);
    ctr_need = {1'b0, it_q.key[CB-1:0]} + (CB+1)'(1);
    if (it_q.key == 32'd0) begin
      uid     = (32'(own) << CB) | 32'(ctr_cur);
      ctr_upd = ctr_nxt;
    end else begin
      uid     = it_q.key;
      ctr_upd = (ctr_nxt > ctr_need) ? ctr_nxt : ctr_need;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    count_d     = count_q;
    cursor_d    = cursor_q;
    pass_d      = pass_q;
    it_d        = it_q;
    qry_d       = qry_q;
    qkey_d      = qkey_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ctr_we      = 1'b0;
    ctr_sel     = own;
    ctr_d       = ctr_upd[CB] ? CB'(sot_pkg::CNT_MIN) : ctr_upd[CB-1:0];
    in_stall_o  = 1'b1;
    ctrl.op      = sot_pkg::CELL_HOLD;
    ctrl.qry     = qry_q;
    ctrl.q_key   = qkey_q;
    ctrl.new_ent = {qkey_q, it_q.obj_handle};
    ctrl.pass    = pass_q;

    case (state_q)
      sot_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          it_d    = in_i;
          state_d = sot_pkg::S_PREP;
        end
      end
      sot_pkg::S_PREP: begin
        cnt_d   = '0;
        qry_d   = sot_pkg::QRY_LB;
        qkey_d  = it_q.key;
        state_d = sot_pkg::S_SRCH;
        case (it_q.mode)
          sot_pkg::MODE_LOOKUP, sot_pkg::MODE_REMOVE: begin
          end
          sot_pkg::MODE_INSERT: begin
            qkey_d = uid;
            ctr_we = 1'b1;
          end
          sot_pkg::MODE_WALK_FIRST: begin
            cursor_d = '0;
            state_d  = sot_pkg::S_DONE;
            if (count_q == '0) begin
              res_d = {sot_pkg::ST_WALK_END, 32'd0, 32'd0, 11'd0};
            end else begin
              pass_d = pass_q + 32'd1;
              res_d  = {sot_pkg::ST_OK, ent[0].handle, ent[0].key, 11'd0};
            end
          end
          sot_pkg::MODE_WALK_NEXT: begin
            if (cursor_q >= IW'(CAPACITY)) begin
              cursor_d = IW'(CAPACITY);
              res_d    = {sot_pkg::ST_WALK_END, 32'd0, 32'd0, 11'(CAPACITY)};
              state_d  = sot_pkg::S_DONE;
            end else begin
              qry_d = sot_pkg::QRY_WALK;
            end
          end
          default: begin
            res_d   = {sot_pkg::ST_NOT_FOUND, 32'd0, 32'd0, 11'd0};
            state_d = sot_pkg::S_DONE;
          end
        endcase
      end
      sot_pkg::S_SRCH: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(NL)) begin
          state_d = sot_pkg::S_EXEC;
        end
      end
      sot_pkg::S_EXEC: begin
        state_d = sot_pkg::S_DONE;
        case (it_q.mode)
          sot_pkg::MODE_LOOKUP: begin
            res_d = found ? {sot_pkg::ST_OK, t_ent.handle, qkey_q, 11'(pos)}
                          : {sot_pkg::ST_NOT_FOUND, 32'd0, qkey_q, 11'(pos)};
          end
          sot_pkg::MODE_REMOVE: begin
            if (found) begin
              ctrl.op = sot_pkg::CELL_DEL;
              count_d = count_q - IW'(1);
              res_d   = {sot_pkg::ST_OK, t_ent.handle, qkey_q, 11'(pos)};
            end else begin
              res_d   = {sot_pkg::ST_NOT_FOUND, 32'd0, qkey_q, 11'(pos)};
            end
          end
          sot_pkg::MODE_INSERT: begin
            if (found) begin
              res_d = {sot_pkg::ST_DUP, 32'd0, qkey_q, 11'(pos)};
            end else if (count_q >= IW'(CAPACITY)) begin
              res_d = {sot_pkg::ST_FULL, 32'd0, qkey_q, 11'(pos)};
            end else begin
              ctrl.op = sot_pkg::CELL_INS;
              count_d = count_q + IW'(1);
              res_d   = {sot_pkg::ST_OK, 32'd0, qkey_q, 11'(pos)};
            end
          end
          default: begin
            // walk next: first unstamped entry past the cursor
            if (t_hit) begin
              ctrl.op  = sot_pkg::CELL_STAMP;
              cursor_d = t_idx;
              res_d    = {sot_pkg::ST_OK, t_ent.handle, t_ent.key, 11'(t_idx)};
            end else begin
              cursor_d = (cur_inc > count_q) ? cur_inc : count_q;
              res_d    = {sot_pkg::ST_WALK_END, 32'd0, 32'd0,
                          11'((cur_inc > count_q) ? cur_inc : count_q)};
            end
          end
        endcase
      end
      sot_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = sot_pkg::S_IDLE;
        end
      end
      default: state_d = sot_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sot_pkg::S_IDLE;
      cnt_q        <= '0;
      count_q      <= '0;
      cursor_q     <= '0;
      pass_q       <= '0;
      dflt_owner_q <= '0;
      out_valid_q  <= 1'b0;
      qry_q        <= sot_pkg::QRY_LB;
      for (int i = 0; i < 8; i++) begin
        ctr_q[i] <= CB'(sot_pkg::CNT_MIN);
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
      qry_q       <= qry_d;
      if (cfg_we_i) begin
        dflt_owner_q <= cfg_wdata_i;
      end
      if (ctr_we) begin
        ctr_q[ctr_sel] <= ctr_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    it_q   <= it_d;
    qkey_q <= qkey_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
endmodule
`default_nettype wire
